// ===== hdl/ptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
// No dependencies; every other file refers to it by scoped names.
package ptw_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned RootW      = 40;
  localparam int unsigned PageNumW   = 36;
  localparam int unsigned AddrW      = 52;
  localparam int unsigned FrameW     = 40;
  localparam int unsigned EntryW     = 64;
  localparam int unsigned IndexW     = 9;

  typedef enum logic [1:0] {
    ACT_TRANSLATE = 2'd0,
    ACT_CHECK     = 2'd1,
    ACT_RESPONSE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    RES_READ       = 2'd0,
    RES_XLATE_DONE = 2'd1,
    RES_CHECK_DONE = 2'd2
  } result_e;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } size_e;

  typedef enum logic [1:0] {
    ITEM_XLATE = 2'd0,
    ITEM_CHECK = 2'd1,
    ITEM_RESP  = 2'd2
  } item_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_L0   = 3'd1,
    ST_L1   = 3'd2,
    ST_L2   = 3'd3,
    ST_L3   = 3'd4
  } walk_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] virtual_address;
    logic [63:0] check_flags;
    logic [1:0]  page_size_kind;
    logic [63:0] entry_data;
  } ptw_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [51:0] read_address;
    logic [51:0] physical_address;
    logic        found;
  } ptw_out_t;

  // Classified item as it sits in the queue: requests carry the flag mask
  // in data, responses carry the table entry.
  typedef struct packed {
    item_e                kind;
    logic [PageNumW-1:0]  page_num;
    logic [EntryW-1:0]    data;
    logic [1:0]           size;
  } ptw_item_t;

endpackage

// ===== hdl/ptw_front.sv =====
// Front end: accepts input transfers, classifies them and queues them.
// Depends on ptw_pkg.
module ptw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptw_pkg::ptw_in_t    in_data_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output ptw_pkg::ptw_item_t  item_o
);

  localparam int unsigned PtrW = (ptw_pkg::QueueDepth > 1) ? $clog2(ptw_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(ptw_pkg::QueueDepth + 1);

  ptw_pkg::ptw_item_t mem_q [ptw_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  ptw_pkg::ptw_item_t item_in;
  logic keep, push, pop;

  // Classify: reserved action codes are taken but dropped here.
  always_comb begin
    keep             = 1'b1;
    item_in.page_num = in_data_i.virtual_address[47:12];
    item_in.size     = in_data_i.page_size_kind;
    item_in.data     = in_data_i.check_flags;
    item_in.kind     = ptw_pkg::ITEM_XLATE;
    unique case (in_data_i.action)
      ptw_pkg::ACT_TRANSLATE: item_in.kind = ptw_pkg::ITEM_XLATE;
      ptw_pkg::ACT_CHECK:     item_in.kind = ptw_pkg::ITEM_CHECK;
      ptw_pkg::ACT_RESPONSE: begin
        item_in.kind = ptw_pkg::ITEM_RESP;
        item_in.data = in_data_i.entry_data;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o   = (cnt_q != CntW'(ptw_pkg::QueueDepth));
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(ptw_pkg::QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(ptw_pkg::QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_in;
    end
  end

endmodule

// ===== hdl/ptw_back.sv =====
// Back end: walk sequencer, root frame register and output register.
// Depends on ptw_pkg.
module ptw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  ptw_pkg::ptw_item_t  item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ptw_pkg::RootW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptw_pkg::ptw_out_t   out_data_o
);

  ptw_pkg::walk_state_e state_q, state_d;
  logic [ptw_pkg::RootW-1:0]    root_q;
  logic [ptw_pkg::PageNumW-1:0] pn_q;
  logic                         chk_q;
  logic [ptw_pkg::EntryW-1:0]   flags_q;
  logic [1:0]                   size_q;
  logic                         out_valid_q, out_valid_d;
  ptw_pkg::ptw_out_t            out_q, out_d;

  logic                         pop, start, emit, finish, hit, rd;
  logic [ptw_pkg::FrameW-1:0]   base, rd_base;
  logic [ptw_pkg::IndexW-1:0]   idx;
  logic                         present, big_page, base_zero;

  assign cfg_ready_o  = 1'b1;
  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  assign base      = item_i.data[51:12];
  assign present   = item_i.data[0];
  assign big_page  = item_i.data[7];
  assign base_zero = (base == '0);

  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    rd      = 1'b0;
    finish  = 1'b0;
    hit     = 1'b0;
    rd_base = base;
    unique case (state_q)
      ptw_pkg::ST_IDLE: begin
        if (pop && item_i.kind != ptw_pkg::ITEM_RESP) begin
          start   = 1'b1;
          rd      = 1'b1;
          rd_base = root_q;
          state_d = ptw_pkg::ST_L0;
        end
      end
      ptw_pkg::ST_L0: begin
        if (pop && item_i.kind == ptw_pkg::ITEM_RESP) begin
          if (chk_q ? ((item_i.data & flags_q) == '0) : !present) begin
            finish = 1'b1;
          end else if (base_zero) begin
            finish = 1'b1;
          end else begin
            rd      = 1'b1;
            state_d = ptw_pkg::ST_L1;
          end
        end
      end
      ptw_pkg::ST_L1: begin
        if (pop && item_i.kind == ptw_pkg::ITEM_RESP) begin
          if (!present) begin
            finish = 1'b1;
          end else if (big_page && (!chk_q || size_q == ptw_pkg::SIZE_1G)) begin
            finish = 1'b1;
            hit    = 1'b1;
          end else if (base_zero) begin
            finish = 1'b1;
          end else begin
            rd      = 1'b1;
            state_d = ptw_pkg::ST_L2;
          end
        end
      end
      ptw_pkg::ST_L2: begin
        if (pop && item_i.kind == ptw_pkg::ITEM_RESP) begin
          // A 2 MiB check takes the size bit ahead of the present bit.
          if (chk_q && size_q == ptw_pkg::SIZE_2M && big_page) begin
            finish = 1'b1;
            hit    = 1'b1;
          end else if (!present) begin
            finish = 1'b1;
          end else if (!chk_q && big_page) begin
            finish = 1'b1;
            hit    = 1'b1;
          end else if (base_zero) begin
            finish = 1'b1;
          end else begin
            rd      = 1'b1;
            state_d = ptw_pkg::ST_L3;
          end
        end
      end
      ptw_pkg::ST_L3: begin
        if (pop && item_i.kind == ptw_pkg::ITEM_RESP) begin
          finish = 1'b1;
          hit    = present;
        end
      end
      default: state_d = ptw_pkg::ST_IDLE;
    endcase
    if (finish) begin
      state_d = ptw_pkg::ST_IDLE;
    end
  end

  // Table index for the level the read goes to; a new walk uses the
  // page number it brings along.
  always_comb begin
    idx = item_i.page_num[35:27];
    case (state_q)
      ptw_pkg::ST_L0: idx = pn_q[26:18];
      ptw_pkg::ST_L1: idx = pn_q[17:9];
      ptw_pkg::ST_L2: idx = pn_q[8:0];
      default:        idx = item_i.page_num[35:27];
    endcase
  end

  assign emit = rd || finish;

  always_comb begin
    out_d = out_q;
    if (rd) begin
      out_d.result_kind      = ptw_pkg::RES_READ;
      out_d.read_address     = {rd_base, idx, 3'b000};
      out_d.physical_address = '0;
      out_d.found            = 1'b0;
    end else if (finish) begin
      out_d.read_address = '0;
      out_d.found        = hit;
      if (chk_q) begin
        out_d.result_kind      = ptw_pkg::RES_CHECK_DONE;
        out_d.physical_address = '0;
      end else begin
        out_d.result_kind      = ptw_pkg::RES_XLATE_DONE;
        out_d.physical_address = hit ? {base, 12'h000} : '0;
      end
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      root_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        root_q <= cfg_data_i;
      end
    end
  end

  // Hold the request context for the rest of the walk.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (start) begin
      pn_q    <= item_i.page_num;
      chk_q   <= (item_i.kind == ptw_pkg::ITEM_CHECK);
      flags_q <= item_i.data;
      size_q  <= item_i.size;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/four_level_page_table_walker.sv =====
// Channel | Dir | Payload                 | Transfer when
// in      | in  | ptw_pkg::ptw_in_t       | in_valid_i && in_ready_o
// out     | out | ptw_pkg::ptw_out_t      | out_valid_o && out_ready_i
// cfg     | in  | root_frame, 40 bits     | cfg_valid_i && cfg_ready_o
//
// One input transfer per cycle while the front queue has room; a result passes
// through the front queue, then the walk sequencer into the output register.
// The two-entry front queue and the output register let either side stall
// without blocking the other. Reset clears the queue, the walk state, the
// output valid and root_frame. Config is always ready.
// Top level of the page table walker; depends on ptw_pkg, ptw_front, ptw_back.
module four_level_page_table_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptw_pkg::ptw_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptw_pkg::ptw_out_t   out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ptw_pkg::RootW-1:0] cfg_data_i
);

  logic               item_valid, item_ready;
  ptw_pkg::ptw_item_t item;

  ptw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  ptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/ptw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker.
module ptw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ptw_pkg::ptw_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_done_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind != ptw_pkg::RES_READ
      |-> out_data_o.read_address == '0)
    else $error("done result carries a read address");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == ptw_pkg::RES_READ
      |-> !out_data_o.found && out_data_o.physical_address == '0)
    else $error("read request carries translation fields");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == ptw_pkg::RES_CHECK_DONE ||
      !out_data_o.found) |-> out_data_o.physical_address == '0)
    else $error("miss or check result carries a frame address");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
